// File: src/cikh_pkg.sv
package cikh_pkg;

  localparam int NumEntries = 256;
  localparam int IdxW = $clog2(NumEntries);
  localparam int CntW = IdxW + 1;
  localparam int KeyW = 32;
  localparam int DataW = 64;
  localparam int CfgW = 9;
  localparam int RemW = KeyW / 2 + 1;
  localparam int ShW = $clog2(KeyW / 2 + 1);
  localparam int DivW = RemW + IdxW;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_OFF  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] entry_data;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [DataW-1:0] read_data;
  } resp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_NODE_RD,
    S_NODE_CHK,
    S_INS_WR,
    S_DEL_WR,
    S_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // capture request
    logic mod_step;    // one step of the modulo reduction
    logic clr_step;    // clear one head and free entry
    logic head_rd;     // read head of bucket
    logic advance;     // move cursor along the chain
    logic ins_wr;
    logic del_wr;
    logic respond;
    logic [1:0] resp_status;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic disabled;
    logic full;
    logic cur_ok;
    logic key_match;
    logic [1:0] command;
  } sts_t;

endpackage

// File: src/chained_int_key_hash_table.sv
// Channel   | Signals                         | Handshake
// ----------+---------------------------------+------------------------------
// request   | start, busy, req (req_t)        | taken when start && !busy
// result    | done, resp (resp_t)             | one-cycle strobe, no stall
// config    | cfg_we, cfg_data                | written when cfg_we
//
// One transaction at a time. After the accept cycle the modulo takes one compare-and-subtract
// step per cycle (up to 17) in S_MOD and reads the bucket head in S_HEAD; an insert then
// writes in S_INS_WR, delete and lookup check each chain node in S_NODE_RD and S_NODE_CHK,
// a miss ends in S_NODE_RD, a delete in S_DEL_WR. Disabled, unused and pool-full commands
// decide in S_MOD. done is registered from the decision and cannot be stalled. Reset or a
// bucket_count write starts a clearing pass of the head table and free stack, with busy high.
module chained_int_key_hash_table
  import cikh_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  req_t            req,
  output logic            done,
  output resp_t           resp,
  input  logic            cfg_we,
  input  logic [CfgW-1:0] cfg_data
);

  ctl_t ctl;
  sts_t sts;

  cikh_ctrl u_ctrl (.clk, .rst, .start, .cfg_we, .sts, .busy, .ctl);
  cikh_dp u_dp (.clk, .rst, .cfg_we, .cfg_data, .req, .ctl, .sts, .done, .resp);

endmodule

// File: src/cikh_ram.sv
module cikh_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/cikh_ctrl.sv
module cikh_ctrl
  import cikh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic cfg_we,
  input  sts_t sts,
  output logic busy,
  output ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else if (cfg_we) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.resp_status = ST_OK;
    busy = 1'b1;
    case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.disabled) begin
          ctl.respond = 1'b1;
          ctl.resp_status = ST_OFF;
          state_next = S_IDLE;
        end else if (sts.command == CMD_NONE) begin
          ctl.respond = 1'b1;
          state_next = S_IDLE;
        end else if (sts.command == CMD_INSERT && sts.full) begin
          ctl.respond = 1'b1;
          ctl.resp_status = ST_FULL;
          state_next = S_IDLE;
        end else if (sts.mod_done) begin
          ctl.head_rd = 1'b1;
          state_next = S_HEAD;
        end else begin
          ctl.mod_step = 1'b1;
        end
      end
      S_HEAD: begin
        // Head entry arrives from RAM; pick up the cursor.
        ctl.advance = 1'b1;
        state_next = (sts.command == CMD_INSERT) ? S_INS_WR : S_NODE_RD;
      end
      S_INS_WR: begin
        ctl.ins_wr = 1'b1;
        ctl.respond = 1'b1;
        state_next = S_IDLE;
      end
      S_NODE_RD: begin
        if (!sts.cur_ok) begin
          ctl.respond = 1'b1;
          ctl.resp_status = ST_MISS;
          state_next = S_IDLE;
        end else begin
          state_next = S_NODE_CHK;
        end
      end
      S_NODE_CHK: begin
        if (sts.key_match) begin
          if (sts.command == CMD_LOOKUP) begin
            ctl.respond = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_DEL_WR;
          end
        end else begin
          ctl.advance = 1'b1;
          state_next = S_NODE_RD;
        end
      end
      S_DEL_WR: begin
        ctl.del_wr = 1'b1;
        ctl.respond = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  property p_resp_idle;
    @(posedge clk) disable iff (rst) ctl.respond && !cfg_we |=> state == S_IDLE;
  endproperty
  assert property (p_resp_idle) else $error("response not followed by idle");

  property p_no_wr_both;
    @(posedge clk) disable iff (rst) !(ctl.ins_wr && ctl.del_wr);
  endproperty
  assert property (p_no_wr_both) else $error("insert and delete write together");

  property p_load_idle;
    @(posedge clk) disable iff (rst) ctl.load |-> !busy;
  endproperty
  assert property (p_load_idle) else $error("request loaded while busy");

endmodule

// File: src/cikh_dp.sv
module cikh_dp
  import cikh_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [CfgW-1:0] cfg_data,
  input  req_t            req,
  input  ctl_t            ctl,
  output sts_t            sts,
  output logic            done,
  output resp_t           resp
);

  logic [CfgW-1:0]  bucket_count;
  logic [CntW-1:0]  count;
  logic [CntW-1:0]  used;
  logic [CntW-1:0]  clr_idx;
  logic             clr_wr;
  logic [1:0]       cmd;
  logic [KeyW-1:0]  key;
  logic [DataW-1:0] data;
  logic [RemW-1:0]  rem;      // 17-bit key fold, reduced by subtraction
  logic [ShW-1:0]   msh;
  logic [DivW-1:0]  divisor;
  logic [IdxW-1:0]  bucket;
  logic             head_first;
  logic             cur_ok;
  logic [IdxW-1:0]  cur;
  logic             prev_ok;
  logic [IdxW-1:0]  prev;

  // RAM ports. Head and link entries carry a valid bit above the node index.
  logic             head_we, link_we, node_we, free_we;
  logic [IdxW-1:0]  head_wa, link_wa, free_wa, head_ra, free_ra;
  logic [IdxW:0]    head_wd, link_wd, head_rd, link_rd;
  logic [IdxW-1:0]  free_wd, free_rd;
  logic [KeyW-1:0]  key_rd;
  logic [DataW-1:0] pay_rd;

  assign count = (bucket_count > CfgW'(NumEntries)) ? CntW'(NumEntries)
                                                    : CntW'(bucket_count);

  assign divisor = DivW'(count) << msh;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= CfgW'(256);
    end else if (cfg_we) begin
      bucket_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      clr_idx <= '0;
      used <= '0;
    end else begin
      if (clr_wr) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (ctl.ins_wr) begin
        used <= used + 1'b1;
      end
      if (ctl.del_wr) begin
        used <= used - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd  <= req.command;
      key  <= req.key;
      data <= req.entry_data;
      rem  <= RemW'(req.key[KeyW-1:KeyW/2]) + RemW'(req.key[KeyW/2-1:0]);
      msh  <= ShW'(KeyW/2);
    end else if (ctl.mod_step) begin
      // Restoring reduction: the divisor shift walks down from 16 to 0, and the
      // remainder is final as soon as it drops below the bucket count.
      if (DivW'(rem) >= divisor) begin
        rem <= rem - RemW'(divisor);
      end
      msh <= msh - 1'b1;
    end
    if (ctl.head_rd) begin
      bucket <= rem[IdxW-1:0];
      prev_ok <= 1'b0;
    end
    if (ctl.advance) begin
      if (head_first) begin
        cur_ok <= head_rd[IdxW];
        cur <= head_rd[IdxW-1:0];
      end else begin
        prev_ok <= 1'b1;
        prev <= cur;
        cur_ok <= link_rd[IdxW];
        cur <= link_rd[IdxW-1:0];
      end
    end
  end

  // First advance after reading the head loads the cursor from the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_first <= 1'b0;
    end else if (ctl.head_rd) begin
      head_first <= 1'b1;
    end else if (ctl.advance) begin
      head_first <= 1'b0;
    end
  end

  // Head table and free stack share the clear sweep.
  assign clr_wr  = ctl.clr_step && !clr_idx[IdxW];

  assign head_we = clr_wr || ctl.ins_wr || (ctl.del_wr && !prev_ok);
  assign head_wa = clr_wr ? clr_idx[IdxW-1:0] : bucket;
  assign head_wd = clr_wr ? '0 : (ctl.ins_wr ? {1'b1, free_rd} : link_rd);
  assign head_ra = rem[IdxW-1:0];

  assign node_we = ctl.ins_wr;
  assign link_we = ctl.ins_wr || (ctl.del_wr && prev_ok);
  assign link_wa = ctl.ins_wr ? free_rd : prev;
  assign link_wd = ctl.ins_wr ? {cur_ok, cur} : link_rd;

  assign free_we = clr_wr || ctl.del_wr;
  assign free_wa = clr_wr ? clr_idx[IdxW-1:0] : IdxW'(used - 1'b1);
  assign free_wd = clr_wr ? clr_idx[IdxW-1:0] : cur;
  assign free_ra = used[IdxW-1:0];

  cikh_ram #(.Width(IdxW+1), .Depth(NumEntries)) u_head (
    .clk, .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_rd));
  cikh_ram #(.Width(KeyW), .Depth(NumEntries)) u_key (
    .clk, .we(node_we), .waddr(free_rd), .wdata(key), .raddr(cur), .rdata(key_rd));
  cikh_ram #(.Width(DataW), .Depth(NumEntries)) u_pay (
    .clk, .we(node_we), .waddr(free_rd), .wdata(data), .raddr(cur), .rdata(pay_rd));
  cikh_ram #(.Width(IdxW+1), .Depth(NumEntries)) u_link (
    .clk, .we(link_we), .waddr(link_wa), .wdata(link_wd), .raddr(cur), .rdata(link_rd));
  cikh_ram #(.Width(IdxW), .Depth(NumEntries)) u_free (
    .clk, .we(free_we), .waddr(free_wa), .wdata(free_wd), .raddr(free_ra), .rdata(free_rd));

  assign sts.clr_done  = clr_idx[IdxW];
  assign sts.mod_done  = (rem < RemW'(count));
  assign sts.disabled  = (count == '0);
  assign sts.full      = (used >= count);
  assign sts.cur_ok    = cur_ok;
  assign sts.key_match = (key_rd == key);
  assign sts.command   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.respond && !cfg_we;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.respond) begin
      resp.status <= ctl.resp_status;
      resp.read_data <= (ctl.resp_status == ST_OK && cmd == CMD_LOOKUP) ? pay_rd : '0;
    end
  end

endmodule

// File: dv/cikh_checker.sv
module cikh_checker
  import cikh_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  req_t            req,
  input  logic            done,
  input  resp_t           resp,
  input  logic            cfg_we,
  input  logic [CfgW-1:0] cfg_data,
  output int              fail_count,
  output int              pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CfgW-1:0]  buckets;
  logic             head_valid [NumEntries];
  logic [IdxW-1:0]  head_idx [NumEntries];
  logic [KeyW-1:0]  key_mem [NumEntries];
  logic [DataW-1:0] data_mem [NumEntries];
  logic [IdxW-1:0]  link_idx [NumEntries];
  logic             link_valid [NumEntries];
  logic [IdxW-1:0]  free_nodes [NumEntries];
  int               in_use;
  resp_t            expected_q [$];

  function automatic void empty_table();
    for (int i = 0; i < NumEntries; i++) begin
      head_valid[i] = 1'b0;
      link_valid[i] = 1'b0;
      free_nodes[i] = i[IdxW-1:0];
    end
    in_use = 0;
  endfunction

  function automatic resp_t hash_op(req_t r);
    resp_t res;
    int cap, b, cur, prev, steps, n;
    logic cur_ok, prev_ok;
    logic [KeyW:0] sum;
    res.status = ST_OK;
    res.read_data = '0;
    cap = (buckets > NumEntries) ? NumEntries : int'(buckets);
    sum = {17'd0, r.key[31:16]} + {17'd0, r.key[15:0]};
    b = (cap == 0) ? 0 : int'(sum) % cap;
    if (cap == 0) begin
      res.status = ST_OFF;
    end else if (r.command == CMD_INSERT) begin
      if (in_use >= cap) begin
        res.status = ST_FULL;
      end else begin
        n = free_nodes[in_use % NumEntries];
        in_use++;
        key_mem[n] = r.key;
        data_mem[n] = r.entry_data;
        link_idx[n] = head_idx[b];
        link_valid[n] = head_valid[b];
        head_idx[b] = n[IdxW-1:0];
        head_valid[b] = 1'b1;
      end
    end else if (r.command == CMD_DELETE || r.command == CMD_LOOKUP) begin
      cur_ok = head_valid[b];
      cur = head_idx[b];
      prev_ok = 1'b0;
      prev = 0;
      steps = 0;
      while (cur_ok && key_mem[cur] != r.key && steps < NumEntries) begin
        prev_ok = 1'b1;
        prev = cur;
        cur_ok = link_valid[cur];
        cur = link_idx[cur];
        steps++;
      end
      if (!cur_ok || key_mem[cur] != r.key) begin
        res.status = ST_MISS;
      end else if (r.command == CMD_LOOKUP) begin
        res.read_data = data_mem[cur];
      end else begin
        if (prev_ok) begin
          link_idx[prev] = link_idx[cur];
          link_valid[prev] = link_valid[cur];
        end else begin
          head_idx[b] = link_idx[cur];
          head_valid[b] = link_valid[cur];
        end
        if (in_use > 0) begin
          in_use--;
          free_nodes[in_use % NumEntries] = cur[IdxW-1:0];
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    resp_t want;
    if (rst) begin
      buckets = 9'd256;
      empty_table();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d data=%h", $time, resp.status,
                   resp.read_data);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (resp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     resp.status);
            fail_count++;
          end
          if (resp.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                     resp.read_data);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        buckets = cfg_data;
        empty_table();
      end
      if (start && !busy) expected_q.push_back(hash_op(req));
    end
    pending_results = expected_q.size();
  end
endmodule

// File: dv/tb_chained_int_key_hash_table.sv
module tb_chained_int_key_hash_table;
  import cikh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  req_t            req = '0;
  logic            done;
  resp_t           resp;
  logic            cfg_we = 1'b0;
  logic [CfgW-1:0] cfg_data = '0;
  int              fail_count;
  int              pending_results;
  int              idle_pct = 0;
  int              idle_cycles = 0;
  logic [KeyW-1:0] key_pool [8];

  chained_int_key_hash_table uut (.*);
  cikh_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: the longest legal quiet stretch is a clearing pass or a full
  // chain walk plus a sender gap, far below this bound.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // start stays high after an accept so that the next transaction can follow
  // without a gap; it drops only in sender pauses and before a drain.
  task automatic send(cmd_t c, logic [KeyW-1:0] k, logic [DataW-1:0] d);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= '{command: c, key: k, entry_data: d};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_buckets(logic [CfgW-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DataW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_phase(int count, int pct);
    int pick;
    logic [KeyW-1:0] k;
    idle_pct = pct;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      k = (pick < 85) ? key_pool[$urandom_range(7)] : $urandom();
      if (pick < 40) send(CMD_INSERT, k, rand64());
      else if (pick < 65) send(CMD_DELETE, k, rand64());
      else if (pick < 95) send(CMD_LOOKUP, k, rand64());
      else send(CMD_NONE, k, rand64());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: extremes, duplicates, misses, unused command.
    send(CMD_LOOKUP, 32'h0, 64'h0);
    send(CMD_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send(CMD_INSERT, 32'hFFFF_FFFF, 64'h1234);
    send(CMD_LOOKUP, 32'hFFFF_FFFF, '0);
    send(CMD_DELETE, 32'hFFFF_FFFF, '0);
    send(CMD_LOOKUP, 32'hFFFF_FFFF, '0);
    send(CMD_INSERT, 32'h0, 64'h0);
    send(CMD_INSERT, 32'h0001_0000, 64'h5);
    send(CMD_LOOKUP, 32'h0, '0);
    send(CMD_DELETE, 32'h1234_5678, '0);
    send(CMD_NONE, 32'h0, 64'hFFFF);
    // Pool full with two buckets; a delete at the head of a chain.
    set_buckets(9'd2);
    for (int i = 0; i < 3; i++) send(CMD_INSERT, KeyW'(i), DataW'(i + 7));
    send(CMD_DELETE, 32'h0, '0);
    send(CMD_LOOKUP, 32'h1, '0);
    set_buckets(9'd0);
    send(CMD_INSERT, 32'h1, 64'h1);
    send(CMD_LOOKUP, 32'h1, '0);
    set_buckets(9'h1FF);
    send(CMD_INSERT, 32'hAAAA_5555, 64'h1);
    send(CMD_LOOKUP, 32'hAAAA_5555, '0);
    set_buckets(9'd1);
    random_phase(120, 0);
    set_buckets(9'd3);
    random_phase(150, 58);
    drain();
    set_buckets(9'd256);
    random_phase(200, 0);
    set_buckets(9'd17);
    random_phase(150, 32);
    set_buckets(9'h1FF);
    random_phase(100, 58);
    set_buckets(9'd0);
    random_phase(20, 0);
    set_buckets(9'd5);
    random_phase(90, 0);
    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
src/cikh_pkg.sv
src/cikh_ram.sv
src/cikh_ctrl.sv
src/cikh_dp.sv
src/chained_int_key_hash_table.sv
dv/cikh_checker.sv
dv/tb_chained_int_key_hash_table.sv
